// ===== hdl/spss_pkg.sv =====
`default_nettype none
package spss_pkg;

  localparam int IDX_W = 5;
  localparam int VAL_W = 32;
  localparam int WGT_W = 16;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_FIND = 2'd2;

  typedef struct packed {
    logic load;
    logic init;
    logic sc_rd;
    logic sc_cmp;
    logic settle;
    logic ed_rd;
    logic ed_hd;
    logic ed_next;
    logic ed_upd;
    logic tr_rd;
    logic tr_ld;
  } cmd_t;

  typedef struct packed {
    logic query_go;
    logic found;
    logic no_edges;
    logic sc_last;
    logic ed_rel;
    logic ed_last;
    logic tr_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/spss_ifs.sv =====
`default_nettype none
interface spss_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [spss_pkg::IDX_W-1:0] node_index;
  logic signed [spss_pkg::VAL_W-1:0] node_value;
  logic [spss_pkg::IDX_W-1:0] src_node;
  logic [spss_pkg::IDX_W-1:0] dst_node;
  logic [spss_pkg::WGT_W-1:0] edge_weight;
  modport source (output valid, req_type, node_index, node_value, src_node, dst_node,
                  edge_weight, input ready);
  modport sink (input valid, req_type, node_index, node_value, src_node, dst_node,
                edge_weight, output ready);
endinterface

interface spss_out_if;
  logic                     valid;
  logic                     ready;
  logic [spss_pkg::IDX_W-1:0] path_index;
  logic signed [spss_pkg::VAL_W-1:0] path_value;
  logic                     is_last;
  modport source (output valid, path_index, path_value, is_last, input ready);
  modport sink (input valid, path_index, path_value, is_last, output ready);
endinterface

interface spss_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [spss_pkg::CNT_W-1:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/shortest_path_search_top.sv =====
`default_nettype none
// Shortest-path search over a stored directed graph.
// in_ch carries request items: set a node value, add an edge, or find a path.
// Set and add-edge items give no result.
// A find item runs Dijkstra from src_node and then sends the path on out_ch,
// target first, one item per node, is_last on the node without parent.
// cfg_ch writes node_count; it is ready whenever reset is released. The user
// must write it only while idle; the block itself does not enforce this.
// in_ch is ready only while no query is at work. A query clears the per-node
// search flags, then repeats a node scan through the distance memory and a
// sweep over the stored edges (no sweep when there are none), relaxing each
// edge that leaves the node just settled toward an unsettled node in range,
// until no reached node is left unsettled; then it walks the path.
// Results sit in an output register; when out_ch stalls, the path walk waits
// and the last item may still be waiting while the next request is taken.
// Reset clears the node-value flags, the edge count, node_count to 32, and the output.
// No clearing pass is needed: per-node search flags are cleared at each query start.
module shortest_path_search_top #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 256
) (
  input wire logic clk,
  input wire logic rst_n,
  spss_in_if.sink    in_ch,
  spss_out_if.source out_ch,
  spss_cfg_if.sink   cfg_ch
);
  import spss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = rst_n;

  spss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spss_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_ch.valid),
    .cfg_data    (cfg_ch.node_count),
    .req_type    (in_ch.req_type),
    .node_index  (in_ch.node_index),
    .node_value  (in_ch.node_value),
    .src_node    (in_ch.src_node),
    .dst_node    (in_ch.dst_node),
    .edge_weight (in_ch.edge_weight),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .path_index  (out_ch.path_index),
    .path_value  (out_ch.path_value),
    .is_last     (out_ch.is_last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
`default_nettype wire

// ===== hdl/spss_ctrl.sv =====
`default_nettype none
module spss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  spss_pkg::sts_t     sts,
  output spss_pkg::cmd_t     cmd
);
  import spss_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_INIT   = 10'b0000000010,
    ST_SC_RD  = 10'b0000000100,
    ST_SC_CMP = 10'b0000001000,
    ST_SETTLE = 10'b0000010000,
    ST_ED_RD  = 10'b0000100000,
    ST_ED_HD  = 10'b0001000000,
    ST_ED_UPD = 10'b0010000000,
    ST_TR_RD  = 10'b0100000000,
    ST_TR_LD  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load = 1'b1;
          if (sts.query_go) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_SC_RD;
      end
      ST_SC_RD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = ST_SC_CMP;
      end
      ST_SC_CMP: begin
        cmd.sc_cmp = 1'b1;
        state_nxt  = sts.sc_last ? ST_SETTLE : ST_SC_RD;
      end
      ST_SETTLE: begin
        cmd.settle = 1'b1;
        if (!sts.found) state_nxt = ST_TR_RD;
        else if (sts.no_edges) state_nxt = ST_SC_RD;
        else state_nxt = ST_ED_RD;
      end
      ST_ED_RD: begin
        cmd.ed_rd = 1'b1;
        state_nxt = ST_ED_HD;
      end
      ST_ED_HD: begin
        cmd.ed_hd = 1'b1;
        if (sts.ed_rel) begin
          state_nxt = ST_ED_UPD;
        end else begin
          cmd.ed_next = 1'b1;
          state_nxt   = sts.ed_last ? ST_SC_RD : ST_ED_RD;
        end
      end
      ST_ED_UPD: begin
        cmd.ed_upd  = 1'b1;
        cmd.ed_next = 1'b1;
        state_nxt   = sts.ed_last ? ST_SC_RD : ST_ED_RD;
      end
      ST_TR_RD: begin
        cmd.tr_rd = 1'b1;
        state_nxt = ST_TR_LD;
      end
      ST_TR_LD: begin
        if (sts.out_free) begin
          cmd.tr_ld = 1'b1;
          state_nxt = sts.tr_last ? ST_IDLE : ST_TR_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/spss_datapath.sv =====
`default_nettype none
module spss_datapath #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [spss_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic [1:0]                    req_type,
  input  wire logic [spss_pkg::IDX_W-1:0]    node_index,
  input  wire logic [spss_pkg::VAL_W-1:0]    node_value,
  input  wire logic [spss_pkg::IDX_W-1:0]    src_node,
  input  wire logic [spss_pkg::IDX_W-1:0]    dst_node,
  input  wire logic [spss_pkg::WGT_W-1:0]    edge_weight,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [spss_pkg::IDX_W-1:0]         path_index,
  output logic [spss_pkg::VAL_W-1:0]         path_value,
  output logic                               is_last,
  input  spss_pkg::cmd_t                     cmd,
  output spss_pkg::sts_t                     sts
);
  import spss_pkg::*;

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int CW  = (NCW > CNT_W) ? NCW : CNT_W;
  localparam int DW  = WGT_W + NW;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * IDX_W + WGT_W;

  logic [CNT_W-1:0] node_count_r;
  logic [NCW-1:0]   n;

  logic [VAL_W-1:0] val_mem_r [MAX_NODES];
  logic [EW-1:0]    edge_mem_r [MAX_EDGES];
  logic [DW-1:0]    dist_mem_r [MAX_NODES];
  logic [NW-1:0]    par_mem_r  [MAX_NODES];

  logic [MAX_NODES-1:0] val_ok_r, reached_r, settled_r, hasp_r;
  logic [ECW-1:0]   edge_cnt_r;
  logic [NW-1:0]    src_r, dst_r;
  logic [NW-1:0]    scan_idx_r, best_r, tr_node_r;
  logic [DW-1:0]    best_dist_r, dist_rd_r;
  logic             found_r;
  logic [EAW-1:0]   eidx_r;
  logic [IDX_W-1:0] e_tail_r, e_head_r;
  logic [WGT_W-1:0] e_w_r;
  logic [NCW-1:0]   k_r;
  logic [VAL_W-1:0] val_rd_r;
  logic             val_ok_rd_r, hasp_rd_r;
  logic [NW-1:0]    par_rd_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_last_r;

  logic           set_ok, edge_ok;
  logic           sc_take, relax;
  logic [NW-1:0]  head_n;
  logic [DW-1:0]  cand;
  logic           dist_we, dist_re;
  logic [NW-1:0]  dist_wa, dist_ra;
  logic [DW-1:0]  dist_wd;

  // Node count as used: zero acts as one, large values clamp to capacity.
  always_comb begin
    if (node_count_r == '0) n = NCW'(1);
    else if (CW'(node_count_r) > CW'(MAX_NODES)) n = NCW'(MAX_NODES);
    else n = NCW'(node_count_r);
  end

  assign set_ok  = (req_type == REQ_SET) && (CW'(node_index) < CW'(n));
  assign edge_ok = (req_type == REQ_EDGE) && (CW'(src_node) < CW'(n)) &&
                   (CW'(dst_node) < CW'(n)) && (edge_cnt_r < ECW'(MAX_EDGES));

  assign head_n  = NW'(e_head_r);
  assign cand    = best_dist_r + DW'(e_w_r);
  assign sc_take = reached_r[scan_idx_r] && !settled_r[scan_idx_r] &&
                   (!found_r || dist_rd_r < best_dist_r);
  assign relax   = !reached_r[head_n] || (cand < dist_rd_r);

  always_comb begin
    dist_we = cmd.init || (cmd.ed_upd && relax);
    dist_wa = cmd.init ? src_r : head_n;
    dist_wd = cmd.init ? '0 : cand;
    dist_re = cmd.sc_rd || cmd.ed_hd;
    dist_ra = cmd.sc_rd ? scan_idx_r : head_n;
  end

  assign sts.query_go = (req_type == REQ_FIND) && (CW'(src_node) < CW'(n)) &&
                        (CW'(dst_node) < CW'(n));
  assign sts.found    = found_r;
  assign sts.no_edges = (edge_cnt_r == '0);
  assign sts.sc_last  = (CW'(scan_idx_r) == CW'(n) - CW'(1));
  assign sts.ed_rel   = (CW'(e_tail_r) == CW'(best_r)) && (CW'(e_head_r) < CW'(n)) &&
                        !settled_r[head_n];
  assign sts.ed_last  = (ECW'(eidx_r) == edge_cnt_r - ECW'(1));
  assign sts.tr_last  = !hasp_rd_r || (CW'(k_r) + CW'(1) >= CW'(n));
  assign sts.out_free = !out_valid_r || out_ready;

  // Memories: no reset, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.load && set_ok) val_mem_r[NW'(node_index)] <= node_value;
    if (cmd.load && edge_ok) edge_mem_r[EAW'(edge_cnt_r)] <= {src_node, dst_node, edge_weight};
    if (dist_we) dist_mem_r[dist_wa] <= dist_wd;
    if (dist_re) dist_rd_r <= dist_mem_r[dist_ra];
    if (cmd.ed_upd && relax) par_mem_r[head_n] <= best_r;
    if (cmd.ed_rd) {e_tail_r, e_head_r, e_w_r} <= edge_mem_r[eidx_r];
    if (cmd.tr_rd) begin
      val_rd_r    <= val_mem_r[tr_node_r];
      val_ok_rd_r <= val_ok_r[tr_node_r];
      par_rd_r    <= par_mem_r[tr_node_r];
      hasp_rd_r   <= hasp_r[tr_node_r];
    end
  end

  // Payload registers of the search.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= NW'(src_node);
      dst_r <= NW'(dst_node);
    end
    if (cmd.sc_cmp) begin
      if (sc_take) begin
        best_r      <= scan_idx_r;
        best_dist_r <= dist_rd_r;
      end
    end
    if (cmd.settle && found_r) eidx_r <= '0;
    else if (cmd.ed_next) eidx_r <= eidx_r + EAW'(1);
    if (cmd.settle && !found_r) begin
      tr_node_r <= dst_r;
      k_r       <= '0;
    end else if (cmd.tr_ld) begin
      tr_node_r <= par_rd_r;
      k_r       <= k_r + NCW'(1);
    end
    if (cmd.tr_ld) begin
      out_idx_r  <= IDX_W'(tr_node_r);
      out_val_r  <= val_ok_rd_r ? val_rd_r : '0;
      out_last_r <= sts.tr_last;
    end
  end

  // Control state and per-node flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      val_ok_r     <= '0;
      reached_r    <= '0;
      settled_r    <= '0;
      hasp_r       <= '0;
      edge_cnt_r   <= '0;
      scan_idx_r   <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) node_count_r <= cfg_data;
      if (cmd.load && set_ok) val_ok_r[NW'(node_index)] <= 1'b1;
      if (cmd.load && edge_ok) edge_cnt_r <= edge_cnt_r + ECW'(1);
      if (cmd.init) begin
        reached_r  <= MAX_NODES'(1) << src_r;
        settled_r  <= '0;
        hasp_r     <= '0;
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      if (cmd.sc_cmp) begin
        scan_idx_r <= scan_idx_r + NW'(1);
        if (sc_take) found_r <= 1'b1;
      end
      if (cmd.settle) begin
        if (found_r) settled_r[best_r] <= 1'b1;
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      if (cmd.ed_upd && relax) begin
        reached_r[head_n] <= 1'b1;
        hasp_r[head_n]    <= 1'b1;
      end
      if (cmd.tr_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign path_index = out_idx_r;
  assign path_value = out_val_r;
  assign is_last    = out_last_r;

endmodule
`default_nettype wire
